/* src/hcd_pkg.sv */
package hcd_pkg;

  localparam int MAX_SIDE = 128;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int PIX_W    = 32;
  localparam int CFG_IDX_W = 4;

  localparam logic [2:0] OP_LOAD_PSF = 3'd0;
  localparam logic [2:0] OP_LOAD_RES = 3'd1;
  localparam logic [2:0] OP_CLEAN    = 3'd2;
  localparam logic [2:0] OP_RD_MODEL = 3'd3;
  localparam logic [2:0] OP_RD_RES   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 4'd3;

  typedef struct packed {
    logic [2:0]               operation;
    logic [13:0]              pixel_index;
    logic signed [PIX_W-1:0]  pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0]  read_value;
    logic [15:0]              components_done;
    logic                     stopped_by_threshold;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  image_side;
    logic [15:0] max_iterations;
    logic [15:0] loop_gain;
    logic [30:0] stop_threshold;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* src/hcd_ram.sv */
module hcd_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  q
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

/* src/hcd_ctrl.sv */
module hcd_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  hcd_pkg::in_item_t       in_item,
  output logic                    busy,
  input  hcd_pkg::cfg_t           cfg,
  output hcd_pkg::ram_req_t       psf_req,
  input  logic [hcd_pkg::PIX_W-1:0] psf_q,
  output hcd_pkg::ram_req_t       res_req,
  input  logic [hcd_pkg::PIX_W-1:0] res_q,
  output hcd_pkg::ram_req_t       mod_req,
  input  logic [hcd_pkg::PIX_W-1:0] mod_q,
  output logic                    out_strobe,
  output hcd_pkg::out_item_t      out_item
);
  import hcd_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_PSCAN  = 14'b00000000000100,
    S_PDRAIN = 14'b00000000001000,
    S_ITER   = 14'b00000000010000,
    S_RSCAN  = 14'b00000000100000,
    S_RDRAIN = 14'b00000001000000,
    S_DECIDE = 14'b00000010000000,
    S_MUL    = 14'b00000100000000,
    S_SUB    = 14'b00001000000000,
    S_SD1    = 14'b00010000000000,
    S_SD2    = 14'b00100000000000,
    S_MRD    = 14'b01000000000000,
    S_MWR    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic              accept;
  logic [SIDE_W-1:0] sm1;
  logic [SIDE_W-1:0] row_r, col_r;
  logic              last_px;
  logic [ADDR_W-1:0] clr_r;
  logic [ADDR_W-1:0] pp_r;
  logic [ADDR_W-1:0] best_addr_r;
  logic [PIX_W-1:0]  best_mag_r;
  logic signed [PIX_W-1:0] best_val_r;
  logic              sc_vld_r, sc_psf_r;
  logic [ADDR_W-1:0] sc_addr_r;
  logic signed [PIX_W-1:0] sc_val;
  logic [PIX_W-1:0]  sc_mag;
  logic [15:0]       done_r;
  logic              stopped_r;
  logic              done_out_r;
  logic signed [48:0] prod_r;
  logic signed [49:0] prod_rnd;
  logic signed [PIX_W-1:0] comp_r;
  logic signed [SIDE_W+2:0] sr, sc;
  logic              sub_in;
  logic              s1_vld_r, s2_vld_r;
  logic [ADDR_W-1:0] s1_addr_r, s2_addr_r;
  logic signed [63:0] mprod_r;
  logic signed [63:0] mrnd;
  logic signed [PIX_W-1:0] resv_r;
  logic signed [48:0] diff;
  logic [PIX_W-1:0]  res_new;
  logic signed [32:0] msum;
  logic [PIX_W-1:0]  mod_new;
  logic              h_vld_r;
  logic [2:0]        h_op_r;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    if (cfg.image_side == 8'd0) begin
      sm1 = '0;
    end else if (cfg.image_side > 8'(MAX_SIDE)) begin
      sm1 = SIDE_W'(MAX_SIDE - 1);
    end else begin
      sm1 = SIDE_W'(cfg.image_side - 8'd1);
    end
  end

  assign last_px = (row_r == sm1) && (col_r == sm1);

  assign sc_val = (sc_psf_r ? psf_q : res_q);
  assign sc_mag = sc_val[PIX_W-1] ? (~sc_val + 1'b1) : sc_val;

  assign sr = $signed({3'b0, row_r}) - $signed({3'b0, best_addr_r[ADDR_W-1:SIDE_W]})
            + $signed({3'b0, pp_r[ADDR_W-1:SIDE_W]});
  assign sc = $signed({3'b0, col_r}) - $signed({3'b0, best_addr_r[SIDE_W-1:0]})
            + $signed({3'b0, pp_r[SIDE_W-1:0]});
  assign sub_in = (sr >= 0) && (sr <= $signed({3'b0, sm1}))
               && (sc >= 0) && (sc <= $signed({3'b0, sm1}));

  assign prod_rnd = 50'(prod_r) + 50'sd32768;
  assign mrnd     = mprod_r + 64'sd32768;
  assign diff     = 49'(resv_r) - 49'(mrnd >>> 16);
  always_comb begin
    if (diff[48:31] == {18{1'b0}} || diff[48:31] == {18{1'b1}}) begin
      res_new = diff[31:0];
    end else if (diff[48]) begin
      res_new = 32'h8000_0000;
    end else begin
      res_new = 32'h7fff_ffff;
    end
  end

  assign msum = 33'($signed(mod_q)) + 33'(comp_r);
  always_comb begin
    if (msum[32] == msum[31]) begin
      mod_new = msum[31:0];
    end else if (msum[32]) begin
      mod_new = 32'h8000_0000;
    end else begin
      mod_new = 32'h7fff_ffff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == {ADDR_W{1'b1}}) state_nxt = S_IDLE;
      S_IDLE:   if (accept && in_item.operation == OP_CLEAN) state_nxt = S_PSCAN;
      S_PSCAN:  if (last_px) state_nxt = S_PDRAIN;
      S_PDRAIN: state_nxt = S_ITER;
      S_ITER:   state_nxt = (done_r == cfg.max_iterations) ? S_IDLE : S_RSCAN;
      S_RSCAN:  if (last_px) state_nxt = S_RDRAIN;
      S_RDRAIN: state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (best_mag_r < {1'b0, cfg.stop_threshold}) ? S_IDLE : S_MUL;
      S_MUL:    state_nxt = S_SUB;
      S_SUB:    if (last_px) state_nxt = S_SD1;
      S_SD1:    state_nxt = S_SD2;
      S_SD2:    state_nxt = S_MRD;
      S_MRD:    state_nxt = S_MWR;
      S_MWR:    state_nxt = S_ITER;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      sc_vld_r   <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      h_vld_r    <= 1'b0;
      done_out_r <= 1'b0;
      pp_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      sc_vld_r   <= (state_r == S_PSCAN) || (state_r == S_RSCAN);
      s1_vld_r   <= (state_r == S_SUB) && sub_in;
      s2_vld_r   <= s1_vld_r;
      h_vld_r    <= accept && (in_item.operation != OP_CLEAN);
      done_out_r <= ((state_r == S_ITER) && (state_nxt == S_IDLE))
                 || ((state_r == S_DECIDE) && (state_nxt == S_IDLE));
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_PDRAIN) begin
        pp_r <= (sc_vld_r && (sc_mag > best_mag_r)) ? sc_addr_r : best_addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc_addr_r <= {row_r, col_r};
    sc_psf_r  <= (state_r == S_PSCAN);
    s1_addr_r <= {row_r, col_r};
    s2_addr_r <= s1_addr_r;
    h_op_r    <= in_item.operation;
    mprod_r   <= 64'(comp_r) * 64'($signed(psf_q));
    resv_r    <= res_q;

    if ((state_r == S_PSCAN) || (state_r == S_RSCAN) || (state_r == S_SUB)) begin
      if (col_r == sm1) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end else begin
      row_r <= '0;
      col_r <= '0;
    end

    if ((accept && in_item.operation == OP_CLEAN) || (state_r == S_ITER)) begin
      best_mag_r  <= '0;
      best_addr_r <= '0;
      best_val_r  <= '0;
    end else if (sc_vld_r && (sc_mag > best_mag_r)) begin
      best_mag_r  <= sc_mag;
      best_addr_r <= sc_addr_r;
      best_val_r  <= sc_val;
    end

    if (accept) begin
      done_r    <= '0;
      stopped_r <= 1'b0;
    end else if (state_r == S_MWR) begin
      done_r <= done_r + 1'b1;
    end else if ((state_r == S_DECIDE) && (state_nxt == S_IDLE)) begin
      stopped_r <= 1'b1;
    end

    if (state_r == S_DECIDE) begin
      prod_r <= 49'($signed({1'b0, cfg.loop_gain})) * 49'(best_val_r);
    end
    if (state_r == S_MUL) begin
      comp_r <= prod_rnd[47:16];
    end
  end

  always_comb begin
    psf_req.we    = accept && (in_item.operation == OP_LOAD_PSF);
    psf_req.waddr = in_item.pixel_index;
    psf_req.wdata = in_item.pixel_value;
    psf_req.raddr = (state_r == S_SUB) ? {sr[SIDE_W-1:0], sc[SIDE_W-1:0]} : {row_r, col_r};

    res_req.we    = s2_vld_r || (accept && (in_item.operation == OP_LOAD_RES));
    res_req.waddr = s2_vld_r ? s2_addr_r : in_item.pixel_index;
    res_req.wdata = s2_vld_r ? res_new : in_item.pixel_value;
    res_req.raddr = (state_r == S_IDLE) ? in_item.pixel_index : {row_r, col_r};

    mod_req.we    = (state_r == S_CLEAR) || (state_r == S_MWR);
    mod_req.waddr = (state_r == S_CLEAR) ? clr_r : best_addr_r;
    mod_req.wdata = (state_r == S_CLEAR) ? '0 : mod_new;
    mod_req.raddr = (state_r == S_IDLE) ? in_item.pixel_index : best_addr_r;
  end

  always_comb begin
    out_strobe = h_vld_r || done_out_r;
    out_item   = '0;
    if (done_out_r) begin
      out_item.components_done      = done_r;
      out_item.stopped_by_threshold = stopped_r;
    end else if (h_op_r == OP_RD_MODEL) begin
      out_item.read_value = mod_q;
    end else if (h_op_r == OP_RD_RES) begin
      out_item.read_value = res_q;
    end
  end

endmodule

/* src/hogbom_clean_deconvolver.sv */
// channel   direction  handshake                        payload
// in_       input      start high, busy low             in_item (in_item_t)
// out_      output     out_strobe, one cycle, no stall  out_item (out_item_t)
// cfg_      input      cfg_valid and cfg_ready          cfg_index, cfg_data
//
// Load and read transactions each give a result in the cycle after they are accepted.
// A clean holds busy for a PSF scan, then per iteration a residual scan, a subtract pass
// and a model update, plus a last residual scan when the threshold ends it; each scan
// covers the S*S region of side S. Its result comes in the first cycle with busy low.
// After reset the model memory is cleared, one word a cycle, all 16384 words, with busy high.
// Results cannot be held off; cfg_ready is always high.
module hogbom_clean_deconvolver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  hcd_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output hcd_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import hcd_pkg::*;

  cfg_t     cfg_r;
  ram_req_t psf_req, res_req, mod_req;
  logic [PIX_W-1:0] psf_q, res_q, mod_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_side     <= 8'd128;
      cfg_r.max_iterations <= 16'd100;
      cfg_r.loop_gain      <= 16'd6554;
      cfg_r.stop_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_SIDE: cfg_r.image_side     <= cfg_data[7:0];
        CFG_MAX_ITER:   cfg_r.max_iterations <= cfg_data[15:0];
        CFG_LOOP_GAIN:  cfg_r.loop_gain      <= cfg_data[15:0];
        CFG_THRESHOLD:  cfg_r.stop_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  hcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .cfg        (cfg_r),
    .psf_req    (psf_req),
    .psf_q      (psf_q),
    .res_req    (res_req),
    .res_q      (res_q),
    .mod_req    (mod_req),
    .mod_q      (mod_q),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  hcd_ram #(.W(PIX_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_psf (
    .clk(clk), .we(psf_req.we), .waddr(psf_req.waddr), .wdata(psf_req.wdata),
    .raddr(psf_req.raddr), .q(psf_q)
  );

  hcd_ram #(.W(PIX_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_res (
    .clk(clk), .we(res_req.we), .waddr(res_req.waddr), .wdata(res_req.wdata),
    .raddr(res_req.raddr), .q(res_q)
  );

  hcd_ram #(.W(PIX_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_mod (
    .clk(clk), .we(mod_req.we), .waddr(mod_req.waddr), .wdata(mod_req.wdata),
    .raddr(mod_req.raddr), .q(mod_q)
  );

endmodule

/* src/hcd_checker.sv */
module hcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input hcd_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input hcd_pkg::out_item_t out_item
);
  import hcd_pkg::*;

  a_clean_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.operation == OP_CLEAN |=> busy)
    else $error("clean transaction did not raise busy");

  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.operation != OP_CLEAN |=> out_strobe && !busy)
    else $error("pixel transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy) || $fell(busy))
    else $error("result without a transaction");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result while busy");

  a_pixel_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.operation != OP_CLEAN |=> out_item.components_done == 16'd0
      && !out_item.stopped_by_threshold)
    else $error("pixel result carries clean status");

endmodule

bind hogbom_clean_deconvolver hcd_checker u_hcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
